// ===== rtl/core/sidt_pkg.sv =====
// ----------------------------------------------------------------------------
// sidt_pkg: shared definitions for the sorted id/handle table
// Widths, command and status codes used by the channel interfaces and the core.
// ----------------------------------------------------------------------------
package sidt_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam int CMD_W    = 2;
	localparam int ID_W     = 32;
	localparam int HANDLE_W = 32;
	localparam int STATUS_W = 3;

	typedef logic [CMD_W-1:0]    cmd_t;
	typedef logic [ID_W-1:0]     id_t;
	typedef logic [HANDLE_W-1:0] handle_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam cmd_t CMD_ADD    = 2'd0;
	localparam cmd_t CMD_REMOVE = 2'd1;
	localparam cmd_t CMD_GET    = 2'd2;
	localparam cmd_t CMD_NONE   = 2'd3;

	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_NOT_FOUND = 3'd1;
	localparam status_t ST_ORDER     = 3'd2;
	localparam status_t ST_FULL      = 3'd3;
	localparam status_t ST_BAD_ID    = 3'd4;

endpackage

// ===== rtl/core/sidt_req_if.sv =====
// ----------------------------------------------------------------------------
// sidt_req_if: command channel
// Valid/ready channel carrying one table command per beat.
// ----------------------------------------------------------------------------
interface sidt_req_if import sidt_pkg::*; ();
	logic    valid;
	logic    ready;
	cmd_t    command;
	id_t     node_id;
	handle_t handle_in;

	modport source (output valid, output command, output node_id, output handle_in,
		input ready);
	modport sink (input valid, input command, input node_id, input handle_in,
		output ready);
endinterface

// ===== rtl/core/sidt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sidt_rsp_if: result channel
// Valid/ready channel carrying one status and handle per beat.
// ----------------------------------------------------------------------------
interface sidt_rsp_if import sidt_pkg::*; ();
	logic    valid;
	logic    ready;
	status_t status;
	handle_t handle_out;

	modport source (output valid, output status, output handle_out, input ready);
	modport sink (input valid, input status, input handle_out, output ready);
endinterface

// ===== rtl/core/sorted_id_handle_table_top.sv =====
// ----------------------------------------------------------------------------
// sorted_id_handle_table_top: sorted id-to-handle table
// Microcoded sequencer over one entry memory: append, binary search, shift down.
// ----------------------------------------------------------------------------
// Channel | Dir | Payload                          | Beat
// req     | in  | command, node_id, handle_in      | one command
// rsp     | out | status, handle_out               | one result per command
//
// Add checks the id, the order and the room, then appends. Get and remove run a
// binary search (at most 7 probes at 64 entries); remove then moves every
// entry above the removed slot down one place, since the single write port
// moves one entry a cycle.
// Reset clears the entry count and sequencer; memory contents are not cleared.
// A new command is taken while the last result still waits on rsp; the core
// stalls only if a second result is ready before the first one is taken.
// ----------------------------------------------------------------------------
module sorted_id_handle_table_top import sidt_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	sidt_req_if.sink   req,
	sidt_rsp_if.source rsp
);

	typedef logic [4:0] pc_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LATCH, OP_MID, OP_NARROW, OP_HIT, OP_SHIFT, OP_DEC,
		OP_APPEND, OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		RD_NONE, RD_LAST, RD_MID, RD_NEXT, RD_NEXT2
	} rd_t;

	typedef enum logic [3:0] {
		C_NEXT, C_ALWAYS, C_NO_IN, C_IS_ADD, C_IS_NONE, C_IS_GET, C_LO_GE_HI,
		C_KEY_EQ, C_SH_END, C_SH_MORE, C_BAD_ID, C_ORDER, C_FULL, C_OUT_FREE
	} cond_t;

	typedef struct packed {
		logic    in_rdy;
		op_t     op;
		rd_t     rd;
		logic    st_we;
		status_t st;
		cond_t   cond;
		pc_t     target;
	} ctl_t;

	typedef struct packed {
		id_t     key;
		handle_t handle;
	} entry_t;

	localparam int EXT_W = CNT_W + 1;

	// program addresses
	localparam pc_t S_WAIT   = 5'd0;
	localparam pc_t S_DISP   = 5'd1;
	localparam pc_t S_NOCMD  = 5'd2;
	localparam pc_t S_PROBE  = 5'd3;
	localparam pc_t S_READ   = 5'd4;
	localparam pc_t S_CMP    = 5'd5;
	localparam pc_t S_LOOP   = 5'd6;
	localparam pc_t S_HIT    = 5'd7;
	localparam pc_t S_SH0    = 5'd8;
	localparam pc_t S_SH1    = 5'd9;
	localparam pc_t S_REND   = 5'd10;
	localparam pc_t S_A0     = 5'd11;
	localparam pc_t S_A1     = 5'd12;
	localparam pc_t S_A2     = 5'd13;
	localparam pc_t S_A3     = 5'd14;
	localparam pc_t S_NF     = 5'd15;
	localparam pc_t S_ORD    = 5'd16;
	localparam pc_t S_FULL   = 5'd17;
	localparam pc_t S_BAD    = 5'd18;
	localparam pc_t S_OK     = 5'd19;
	localparam pc_t S_OUT    = 5'd20;
	localparam pc_t S_STALL  = 5'd21;

	function automatic ctl_t ucode(pc_t a);
		ctl_t w;
		w = '{in_rdy: 1'b0, op: OP_NONE, rd: RD_NONE, st_we: 1'b0, st: ST_OK,
			cond: C_NEXT, target: S_WAIT};
		case (a)
			S_WAIT: begin
				w.in_rdy = 1'b1; w.op = OP_LATCH; w.rd = RD_LAST;
				w.cond = C_NO_IN; w.target = S_WAIT;
			end
			S_DISP: begin
				w.cond = C_IS_ADD; w.target = S_A0;
			end
			S_NOCMD: begin
				w.cond = C_IS_NONE; w.target = S_NF;
			end
			S_PROBE: begin
				w.op = OP_MID; w.cond = C_LO_GE_HI; w.target = S_NF;
			end
			S_READ: begin
				w.rd = RD_MID;
			end
			S_CMP: begin
				w.op = OP_NARROW; w.cond = C_KEY_EQ; w.target = S_HIT;
			end
			S_LOOP: begin
				w.cond = C_ALWAYS; w.target = S_PROBE;
			end
			S_HIT: begin
				w.op = OP_HIT; w.cond = C_IS_GET; w.target = S_OK;
			end
			S_SH0: begin
				w.rd = RD_NEXT; w.cond = C_SH_END; w.target = S_REND;
			end
			S_SH1: begin
				w.op = OP_SHIFT; w.rd = RD_NEXT2; w.cond = C_SH_MORE; w.target = S_SH1;
			end
			S_REND: begin
				w.op = OP_DEC; w.st_we = 1'b1; w.st = ST_OK;
				w.cond = C_ALWAYS; w.target = S_OUT;
			end
			S_A0: begin
				w.cond = C_BAD_ID; w.target = S_BAD;
			end
			S_A1: begin
				w.cond = C_ORDER; w.target = S_ORD;
			end
			S_A2: begin
				w.cond = C_FULL; w.target = S_FULL;
			end
			S_A3: begin
				w.op = OP_APPEND; w.st_we = 1'b1; w.st = ST_OK;
				w.cond = C_ALWAYS; w.target = S_OUT;
			end
			S_NF: begin
				w.st_we = 1'b1; w.st = ST_NOT_FOUND; w.cond = C_ALWAYS; w.target = S_OUT;
			end
			S_ORD: begin
				w.st_we = 1'b1; w.st = ST_ORDER; w.cond = C_ALWAYS; w.target = S_OUT;
			end
			S_FULL: begin
				w.st_we = 1'b1; w.st = ST_FULL; w.cond = C_ALWAYS; w.target = S_OUT;
			end
			S_BAD: begin
				w.st_we = 1'b1; w.st = ST_BAD_ID; w.cond = C_ALWAYS; w.target = S_OUT;
			end
			S_OK: begin
				w.st_we = 1'b1; w.st = ST_OK;
			end
			S_OUT: begin
				w.op = OP_EMIT; w.cond = C_OUT_FREE; w.target = S_WAIT;
			end
			S_STALL: begin
				w.cond = C_ALWAYS; w.target = S_OUT;
			end
			default: begin
				w.cond = C_ALWAYS; w.target = S_WAIT;
			end
		endcase
		return w;
	endfunction

	// sequencer and result register
	pc_t              pc_q;
	logic [CNT_W-1:0] count_q;
	logic             res_valid_q;
	status_t          res_status_q;
	handle_t          res_handle_q;

	// datapath registers
	cmd_t             cmd_q;
	id_t              id_q;
	handle_t          hin_q;
	handle_t          hout_q;
	status_t          status_q;
	logic [CNT_W-1:0] lo_q;
	logic [CNT_W-1:0] hi_q;
	logic [IDX_W-1:0] mid_q;
	logic [IDX_W-1:0] slot_q;
	entry_t           rdata_q;
	entry_t           entry_mem [CAPACITY];

	ctl_t             ctl;
	logic             take;
	logic             in_acc;
	logic             out_free;
	logic [EXT_W-1:0] count_x;
	logic [EXT_W-1:0] slot_p1;
	logic [EXT_W-1:0] slot_p2;
	logic [CNT_W-1:0] cnt_m1;
	logic [EXT_W-1:0] mid_sum;
	logic [IDX_W-1:0] rd_addr;
	logic             rd_en;
	logic             mem_we;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;

	assign ctl      = ucode(pc_q);
	assign req.ready = ctl.in_rdy;
	assign in_acc   = req.valid && ctl.in_rdy;
	assign out_free = !res_valid_q || rsp.ready;

	assign rsp.valid      = res_valid_q;
	assign rsp.status     = res_status_q;
	assign rsp.handle_out = res_handle_q;

	assign count_x = EXT_W'(count_q);
	assign slot_p1 = EXT_W'(slot_q) + EXT_W'(1);
	assign slot_p2 = EXT_W'(slot_q) + EXT_W'(2);
	assign cnt_m1  = count_q - CNT_W'(1);
	assign mid_sum = EXT_W'(lo_q) + EXT_W'(hi_q);

	always_comb begin
		case (ctl.cond)
			C_NEXT:     take = 1'b0;
			C_ALWAYS:   take = 1'b1;
			C_NO_IN:    take = !in_acc;
			C_IS_ADD:   take = (cmd_q == CMD_ADD);
			C_IS_NONE:  take = (cmd_q == CMD_NONE);
			C_IS_GET:   take = (cmd_q == CMD_GET);
			C_LO_GE_HI: take = (lo_q >= hi_q);
			C_KEY_EQ:   take = (rdata_q.key == id_q);
			C_SH_END:   take = (slot_p1 >= count_x);
			C_SH_MORE:  take = (slot_p2 < count_x);
			C_BAD_ID:   take = (id_q == '1);
			C_ORDER:    take = (count_q != '0) && (rdata_q.key >= id_q);
			C_FULL:     take = (count_q == CNT_W'(CAPACITY));
			C_OUT_FREE: take = out_free;
			default:    take = 1'b0;
		endcase
	end

	always_comb begin
		rd_en = (ctl.rd != RD_NONE);
		case (ctl.rd)
			RD_LAST:  rd_addr = cnt_m1[IDX_W-1:0];
			RD_NEXT:  rd_addr = slot_p1[IDX_W-1:0];
			RD_NEXT2: rd_addr = slot_p2[IDX_W-1:0];
			default:  rd_addr = mid_q;
		endcase
		mem_we  = (ctl.op == OP_SHIFT) || (ctl.op == OP_APPEND);
		wr_addr = (ctl.op == OP_SHIFT) ? slot_q : count_q[IDX_W-1:0];
		wr_data = (ctl.op == OP_SHIFT) ? rdata_q : entry_t'{key: id_q, handle: hin_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q         <= S_WAIT;
			count_q      <= '0;
			res_valid_q  <= 1'b0;
			res_status_q <= ST_OK;
			res_handle_q <= '0;
		end else begin
			pc_q <= take ? ctl.target : pc_q + 5'd1;
			if (ctl.op == OP_APPEND) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctl.op == OP_DEC) begin
				count_q <= cnt_m1;
			end
			// load the result register only once the previous beat has left
			if (ctl.op == OP_EMIT && out_free) begin
				res_valid_q  <= 1'b1;
				res_status_q <= status_q;
				res_handle_q <= hout_q;
			end else if (rsp.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LATCH: begin
				if (in_acc) begin
					cmd_q  <= req.command;
					id_q   <= req.node_id;
					hin_q  <= req.handle_in;
					hout_q <= '0;
					lo_q   <= '0;
					hi_q   <= count_q;
				end
			end
			OP_MID: mid_q <= mid_sum[IDX_W:1];
			OP_NARROW: begin
				if (rdata_q.key < id_q) begin
					lo_q <= CNT_W'(mid_q) + CNT_W'(1);
				end else begin
					hi_q <= CNT_W'(mid_q);
				end
			end
			OP_HIT: begin
				hout_q <= rdata_q.handle;
				slot_q <= mid_q;
			end
			OP_SHIFT: slot_q <= slot_q + IDX_W'(1);
			default: ;
		endcase
		if (ctl.st_we) begin
			status_q <= ctl.st;
		end
	end

	// entry memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= entry_mem[rd_addr];
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == OP_APPEND) |-> (count_q < CNT_W'(CAPACITY)))
		else $error("append into a full table");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (CNT_W'(wr_addr) <= count_q))
		else $error("memory write above the filled region");

	a_fail_handle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != ST_OK) |-> (rsp.handle_out == '0))
		else $error("failed result carries a handle");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("second command taken while one is in flight");

endmodule
